// ===== sv/egs_pkg.sv =====
// ----------------------------------------------------------------------------
// egs_pkg: shared types and constants of the epoch goodness scheduler
// process table entry layout, run state codes and saturation limits
// ----------------------------------------------------------------------------
`default_nettype none

package egs_pkg;

  localparam int unsigned PID_W   = 5;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned GOOD_W  = 10;

  localparam logic [CNT_W-1:0]  CNT_MAX  = 9'd511;
  localparam logic [GOOD_W-1:0] GOOD_MAX = 10'd1023;

  // kind of an input transfer, carried in tuser
  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_RESCHED = 1'b1;

  typedef enum logic [1:0] {
    ST_BLOCKED = 2'd0,
    ST_READY   = 2'd1,
    ST_CURRENT = 2'd2
  } run_state_e;

  typedef struct packed {
    run_state_e         state;
    logic [PRIO_W-1:0]  prio;
    logic [CNT_W-1:0]   cnt;
    logic [GOOD_W-1:0]  good;
  } proc_entry_t;

endpackage : egs_pkg

`default_nettype wire

// ===== sv/egs_cell.sv =====
// ----------------------------------------------------------------------------
// egs_cell: one slot of the rotating process table
// holds one entry and takes its neighbor's entry on every shift
// ----------------------------------------------------------------------------
`default_nettype none

module egs_cell
  import egs_pkg::*;
#(
  parameter bit RST_CURRENT = 1'b0
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              shift_i,
  input  wire proc_entry_t entry_i,
  output proc_entry_t      entry_o
);

  proc_entry_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q.state <= RST_CURRENT ? ST_CURRENT : ST_BLOCKED;
      entry_q.prio  <= '0;
      entry_q.cnt   <= '0;
      entry_q.good  <= '0;
    end else if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule : egs_cell

`default_nettype wire

// ===== sv/epoch_goodness_scheduler.sv =====
// ----------------------------------------------------------------------------
// epoch_goodness_scheduler: epoch based goodness process scheduler
// process table kept in a ring of cells that rotates past one update unit
// ----------------------------------------------------------------------------
// The process table lives in a ring of NUM_PROCS cells that rotates by one
// slot per cycle, save for the hold on the final slot described below, past
// a single update unit at the tail, so every operation is a whole number of
// rotations and the table is back in home position at the end. A write
// transfer (tuser = 0) takes a single rotation; a reschedule transfer
// (tuser = 1) takes three rotations: charge the running process, then an
// optional new epoch together with the goodness search, then the run state
// commit. One item is worked on at a time; the result sits in an output
// register, so the next item is accepted while that result still waits.
// The final slot of a write or of the commit rotation waits as long as an
// earlier result is still held in the output register.
// A write to a pid at or above NUM_PROCS leaves the table alone but still
// gives a result. next_pid carries the low five bits of the running pid.
`default_nettype none

module epoch_goodness_scheduler
  import egs_pkg::*;
#(
  parameter int unsigned NUM_PROCS = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input stream
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [4:0] pid, [12:5] priority_req, [13] make_ready, [22:14] ticks_left
  input  wire  [23:0] s_axis_tdata_i,
  // [0] action
  input  wire  [0:0]  s_axis_tuser_i,
  // result stream
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  // [4:0] next_pid, [5] switched, [6] new_epoch, [15:7] slice_ticks
  output logic [15:0] m_axis_tdata_o
);

  localparam int unsigned IW = $clog2(NUM_PROCS);
  // common width for comparing a slot index with an input pid
  localparam int unsigned MW = (IW > PID_W) ? IW : PID_W;
  localparam logic [IW-1:0] IDX_LAST = IW'(NUM_PROCS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_CHARGE,
    S_SELECT,
    S_COMMIT
  } state_e;

  state_e state_q;

  // latched input transfer
  logic [PID_W-1:0]  pid_q;
  logic [PRIO_W-1:0] prio_q;
  logic              ready_q;
  logic [CNT_W-1:0]  ticks_q;

  // scheduler bookkeeping
  logic [IW-1:0]     idx_q;       // pid of the entry at the ring tail
  logic [IW-1:0]     cur_q;       // running pid
  logic              runnable_q;  // some runnable slot still has ticks
  logic              epoch_q;
  logic [GOOD_W-1:0] best_q;
  logic [IW-1:0]     best_pid_q;
  logic [CNT_W-1:0]  best_cnt_q;
  run_state_e        cur_state_q;
  logic [GOOD_W-1:0] cur_good_q;
  logic [CNT_W-1:0]  cur_cnt_q;

  logic              m_valid_q;
  logic [15:0]       m_data_q;

  // ring of cells
  proc_entry_t cell_out [NUM_PROCS];
  proc_entry_t tail;
  proc_entry_t head_d;
  logic        shift;

  // control
  logic        s_fire;
  logic        m_fire;
  logic        last;
  logic        load_slot;
  logic        out_free;
  logic        advance;
  logic        keep;
  logic        runnable_now;
  logic [IW-1:0] final_pid;
  logic [MW-1:0] pid_ext;
  logic [MW-1:0] idx_ext;
  logic [MW-1:0] cur_ext;
  logic [MW-1:0] final_ext;

  // update unit arithmetic
  logic [GOOD_W-1:0] chg_base;
  logic [GOOD_W:0]   chg_sum;
  logic [CNT_W:0]    ep_cnt_sum;
  logic [CNT_W-1:0]  ep_cnt;
  logic [GOOD_W:0]   ep_good_sum;

  genvar k;
  generate
    for (k = 0; k < NUM_PROCS; k++) begin : g_cell
      // cell k holds pid NUM_PROCS-1-k at home, so the tail holds pid 0
      egs_cell #(
        .RST_CURRENT(k == NUM_PROCS - 1)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .entry_i ((k == 0) ? head_d : cell_out[(k == 0) ? 0 : k - 1]),
        .entry_o (cell_out[k])
      );
    end
  endgenerate

  assign tail = cell_out[NUM_PROCS-1];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire   = m_valid_q && m_axis_tready_i;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign last     = (idx_q == IDX_LAST);
  // final slot of a write or of the commit loads the result register
  assign load_slot = last && ((state_q == S_WRITE) || (state_q == S_COMMIT));
  // hold the ring on that slot until the result register can load
  assign advance  = !(load_slot && !out_free);
  assign shift    = (state_q != S_IDLE) && advance;

  assign pid_ext = MW'(pid_q);
  assign idx_ext = MW'(idx_q);
  assign cur_ext = MW'(cur_q);

  // keep the running process while it is still current, unless a ready one beats it
  assign keep      = (cur_state_q == ST_CURRENT) && (best_q <= cur_good_q);
  assign final_pid = keep ? cur_q : best_pid_q;
  assign final_ext = MW'(final_pid);

  // charge arithmetic
  assign chg_base = (tail.good > GOOD_W'(tail.cnt)) ? (tail.good - GOOD_W'(tail.cnt)) : '0;
  assign chg_sum  = (GOOD_W+1)'(chg_base) + (GOOD_W+1)'(ticks_q);

  // epoch recompute: counter/2 + priority, goodness = counter + priority
  assign ep_cnt_sum  = (CNT_W+1)'(tail.cnt >> 1) + (CNT_W+1)'(tail.prio);
  assign ep_cnt      = (ep_cnt_sum > (CNT_W+1)'(CNT_MAX)) ? CNT_MAX : ep_cnt_sum[CNT_W-1:0];
  assign ep_good_sum = (GOOD_W+1)'(ep_cnt) + (GOOD_W+1)'(tail.prio);

  // update unit at the ring tail
  always_comb begin
    head_d       = tail;
    runnable_now = 1'b0;
    case (state_q)
      S_WRITE: begin
        if (idx_ext == pid_ext) begin
          head_d.prio = prio_q;
          head_d.cnt  = '0;
          head_d.good = '0;
          if (!ready_q) begin
            head_d.state = ST_BLOCKED;
          end else if (tail.state != ST_CURRENT) begin
            head_d.state = ST_READY;
          end
        end
      end
      S_CHARGE: begin
        if (idx_q == cur_q) begin
          head_d.cnt = ticks_q;
          if (ticks_q == '0) begin
            head_d.good = '0;
          end else begin
            head_d.good = (chg_sum > (GOOD_W+1)'(GOOD_MAX)) ? GOOD_MAX
                                                            : chg_sum[GOOD_W-1:0];
          end
        end
        runnable_now = (head_d.state inside {ST_READY, ST_CURRENT}) && (head_d.cnt != '0);
      end
      S_SELECT: begin
        if (epoch_q) begin
          head_d.cnt  = ep_cnt;
          head_d.good = (ep_good_sum > (GOOD_W+1)'(GOOD_MAX)) ? GOOD_MAX
                                                              : ep_good_sum[GOOD_W-1:0];
        end
      end
      S_COMMIT: begin
        if (!keep) begin
          if ((idx_q == cur_q) && (tail.state == ST_CURRENT)) begin
            head_d.state = ST_READY;
          end
          if (idx_q == best_pid_q) begin
            head_d.state = ST_CURRENT;
          end
        end
      end
      default: ;
    endcase
  end

  // sequencer, bookkeeping and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pid_q       <= '0;
      prio_q      <= '0;
      ready_q     <= 1'b0;
      ticks_q     <= '0;
      idx_q       <= '0;
      cur_q       <= '0;
      runnable_q  <= 1'b0;
      epoch_q     <= 1'b0;
      best_q      <= '0;
      best_pid_q  <= '0;
      best_cnt_q  <= '0;
      cur_state_q <= ST_BLOCKED;
      cur_good_q  <= '0;
      cur_cnt_q   <= '0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
    end else begin
      if (shift && load_slot) begin
        m_valid_q <= 1'b1;
      end else if (m_fire) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            pid_q      <= s_axis_tdata_i[4:0];
            prio_q     <= s_axis_tdata_i[12:5];
            ready_q    <= s_axis_tdata_i[13];
            ticks_q    <= s_axis_tdata_i[22:14];
            idx_q      <= '0;
            runnable_q <= 1'b0;
            state_q    <= (s_axis_tuser_i[0] == ACT_WRITE) ? S_WRITE : S_CHARGE;
          end
        end
        S_WRITE: begin
          if (advance) begin
            idx_q <= last ? '0 : idx_q + 1'b1;
            if (last) begin
              m_data_q  <= {9'd0, 1'b0, 1'b0, cur_ext[PID_W-1:0]};
              state_q   <= S_IDLE;
            end
          end
        end
        S_CHARGE: begin
          if (advance) begin
            idx_q      <= last ? '0 : idx_q + 1'b1;
            runnable_q <= runnable_q || runnable_now;
            if (last) begin
              epoch_q <= !(runnable_q || runnable_now);
              state_q <= S_SELECT;
            end
          end
        end
        S_SELECT: begin
          if (advance) begin
            idx_q <= last ? '0 : idx_q + 1'b1;
            // pid 0 seeds the search and is the fallback
            if (idx_q == '0) begin
              best_q     <= (head_d.state == ST_READY) ? head_d.good : '0;
              best_pid_q <= '0;
              best_cnt_q <= head_d.cnt;
            end else if ((head_d.state == ST_READY) && (head_d.good > best_q)) begin
              best_q     <= head_d.good;
              best_pid_q <= idx_q;
              best_cnt_q <= head_d.cnt;
            end
            if (idx_q == cur_q) begin
              cur_state_q <= head_d.state;
              cur_good_q  <= head_d.good;
              cur_cnt_q   <= head_d.cnt;
            end
            if (last) begin
              state_q <= S_COMMIT;
            end
          end
        end
        S_COMMIT: begin
          if (advance) begin
            idx_q <= last ? '0 : idx_q + 1'b1;
            if (last) begin
              cur_q     <= final_pid;
              m_data_q  <= {keep ? cur_cnt_q : best_cnt_q,
                            epoch_q,
                            !keep && (best_pid_q != cur_q),
                            final_ext[PID_W-1:0]};
              state_q   <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule : epoch_goodness_scheduler

`default_nettype wire

// ===== sv/egs_checker.sv =====
// ----------------------------------------------------------------------------
// egs_checker: port level checks of the epoch goodness scheduler
// watches the stream ports over time and is bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module egs_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid_i,
  input wire        s_axis_tready_o,
  input wire        m_axis_tvalid_o,
  input wire        m_axis_tready_i,
  input wire [15:0] m_axis_tdata_o
);

  logic s_fire;
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;

  // an accepted item keeps the block busy for at least one rotation
  a_busy_after_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready_o
  ) else $error("input accepted twice in a row");

  // a result only appears at the end of a busy period
  a_result_after_work : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o)
  ) else $error("result without preceding work");

  // stalled result holds
  a_result_stable : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o))
  ) else $error("stalled result changed");

endmodule : egs_checker

bind epoch_goodness_scheduler egs_checker u_egs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

// ===== tb/sv/epoch_goodness_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// epoch_goodness_scheduler_tb: self-checking bench for the goodness scheduler
// drives process table writes and reschedule requests over the input stream,
// predicts every result with a behavioral copy of the table and compares each
// result transfer field by field, under random stalls on both sides
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_goodness_scheduler_tb
  import egs_pkg::*;
();

  localparam int unsigned NUM_PROCS    = 32;
  localparam int unsigned STALL_LIMIT  = 3000;  // cycles with no transfer at all
  localparam int unsigned SETTLE_CYCLES = 200;  // > 3 rotations of the table

  typedef struct {
    logic [PID_W-1:0] pid;
    logic             sw;
    logic             epoch;
    logic [CNT_W-1:0] slice;
  } sched_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;  // [4:0] pid, [12:5] prio, [13] ready, [22:14] ticks
  logic [0:0]  s_axis_tuser_i = ACT_WRITE;  // [0] action
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;  // [4:0] next_pid, [5] switched, [6] new_epoch, [15:7] slice

  // predicted copy of the process table
  run_state_e        sched_state [NUM_PROCS];
  logic [PRIO_W-1:0] sched_prio  [NUM_PROCS];
  logic [CNT_W-1:0]  sched_cnt   [NUM_PROCS];
  logic [GOOD_W-1:0] sched_good  [NUM_PROCS];
  logic [PID_W-1:0]  sched_running;

  sched_result_t pending_results[$];
  int unsigned   mismatch_cnt = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;

  epoch_goodness_scheduler #(
    .NUM_PROCS(NUM_PROCS)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #4 clk_i = ~clk_i;

  // table as it stands after reset: slot 0 current, everything else blocked
  task automatic clear_sched_table();
    for (int i = 0; i < NUM_PROCS; i++) begin
      sched_state[i] = ST_BLOCKED;
      sched_prio[i]  = '0;
      sched_cnt[i]   = '0;
      sched_good[i]  = '0;
    end
    sched_state[0] = ST_CURRENT;
    sched_running  = '0;
  endtask

  // one item against the predicted table, returns the result it must give
  task automatic predict_schedule(input logic act, input logic [PID_W-1:0] pid,
                                  input logic [PRIO_W-1:0] prio, input logic rdy,
                                  input logic [CNT_W-1:0] ticks,
                                  output sched_result_t res);
    int unsigned cur;
    int unsigned g;
    int unsigned c;
    int unsigned base;
    int unsigned best;
    int unsigned best_pid;
    bit          epoch;
    res = '{pid: sched_running, sw: 1'b0, epoch: 1'b0, slice: '0};
    if (act == ACT_WRITE) begin
      if (32'(pid) < NUM_PROCS) begin
        sched_prio[pid] = prio;
        sched_cnt[pid]  = '0;
        sched_good[pid] = '0;
        if (!rdy) begin
          sched_state[pid] = ST_BLOCKED;
        end else if (sched_state[pid] != ST_CURRENT) begin
          sched_state[pid] = ST_READY;
        end
      end
      return;
    end
    // charge goes to the running slot whatever its state
    cur = 32'(sched_running);
    if (ticks == '0) begin
      sched_good[cur] = '0;
      sched_cnt[cur]  = '0;
    end
    g    = 32'(sched_good[cur]);
    c    = 32'(sched_cnt[cur]);
    base = (g > c) ? g - c : 0;
    g    = base + 32'(ticks);
    if (g > 32'(GOOD_MAX)) g = 32'(GOOD_MAX);
    sched_good[cur] = GOOD_W'(g);
    sched_cnt[cur]  = ticks;
    // new epoch only when no runnable slot has ticks left
    epoch = 1'b1;
    for (int i = 0; i < NUM_PROCS; i++) begin
      if ((sched_state[i] == ST_READY || sched_state[i] == ST_CURRENT) && sched_cnt[i] != '0)
        epoch = 1'b0;
    end
    if (epoch) begin
      for (int i = 0; i < NUM_PROCS; i++) begin
        c = 32'(sched_cnt[i]) / 2 + 32'(sched_prio[i]);
        if (c > 32'(CNT_MAX)) c = 32'(CNT_MAX);
        sched_cnt[i]  = CNT_W'(c);
        g = c + 32'(sched_prio[i]);
        if (g > 32'(GOOD_MAX)) g = 32'(GOOD_MAX);
        sched_good[i] = GOOD_W'(g);
      end
    end
    // strict compare: lowest pid wins a tie, zero goodness never wins
    best     = 0;
    best_pid = 0;
    for (int i = 0; i < NUM_PROCS; i++) begin
      if (sched_state[i] == ST_READY && 32'(sched_good[i]) > best) begin
        best     = 32'(sched_good[i]);
        best_pid = 32'(i);
      end
    end
    if (!(sched_state[cur] == ST_CURRENT && best <= 32'(sched_good[cur]))) begin
      if (sched_state[cur] == ST_CURRENT) sched_state[cur] = ST_READY;
      sched_state[best_pid] = ST_CURRENT;
      sched_running         = PID_W'(best_pid);
      res.sw                = (best_pid != cur);
    end
    res.pid   = sched_running;
    res.epoch = epoch;
    res.slice = sched_cnt[sched_running];
  endtask

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(input logic act, input logic [PID_W-1:0] pid,
                           input logic [PRIO_W-1:0] prio, input logic rdy,
                           input logic [CNT_W-1:0] ticks);
    sched_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, ticks, rdy, prio, pid};
    s_axis_tuser_i  <= act;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_schedule(act, pid, prio, rdy, ticks, res);
    pending_results.push_back(res);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [PRIO_W-1:0] rand_prio();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PRIO_W'($urandom_range(255));
    endcase
  endfunction

  // expired slices are common so that epochs keep coming
  function automatic logic [CNT_W-1:0] rand_ticks();
    case ($urandom_range(7))
      0, 1, 2: return '0;
      3:       return '1;
      4:       return CNT_W'($urandom_range(8, 1));
      default: return CNT_W'($urandom_range(511, 1));
    endcase
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, got_v);
      mismatch_cnt++;
    end
  endtask

  // result side: random backpressure, checking, and the no-progress watchdog
  always @(posedge clk_i) begin
    sched_result_t exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, m_axis_tdata_o);
          mismatch_cnt++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("next_pid", 32'(exp_r.pid), 32'(m_axis_tdata_o[4:0]));
          check_field("switched", 32'(exp_r.sw), 32'(m_axis_tdata_o[5]));
          check_field("new_epoch", 32'(exp_r.epoch), 32'(m_axis_tdata_o[6]));
          check_field("slice_ticks", 32'(exp_r.slice), 32'(m_axis_tdata_o[15:7]));
        end
      end
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
    m_axis_tready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // hand-picked sequence through every special case of the scheduler
  task automatic test_corner_cases();
    send_item(ACT_RESCHED, 5'd0, 8'd0, 1'b0, 9'd0);      // empty table, epoch, keep 0
    send_item(ACT_WRITE, 5'd31, 8'd255, 1'b1, 9'd511);   // ticks field ignored on write
    send_item(ACT_WRITE, 5'd5, 8'd0, 1'b1, 9'd0);        // ready but zero goodness
    send_item(ACT_RESCHED, 5'd0, 8'd0, 1'b0, 9'd0);      // epoch, 31 takes over
    send_item(ACT_RESCHED, 5'd31, 8'd255, 1'b1, 9'd511); // max charge, keep 31
    send_item(ACT_WRITE, 5'd31, 8'd100, 1'b1, 9'd0);     // ready write to running slot
    send_item(ACT_RESCHED, 5'd0, 8'd0, 1'b0, 9'd1);
    send_item(ACT_WRITE, 5'd31, 8'd7, 1'b0, 9'd0);       // block the running slot
    send_item(ACT_RESCHED, 5'd0, 8'd0, 1'b0, 9'd3);      // charge blocked, fall back to 0
    send_item(ACT_WRITE, 5'd0, 8'd255, 1'b1, 9'd0);
    send_item(ACT_WRITE, 5'd17, 8'd255, 1'b1, 9'd0);
    send_item(ACT_RESCHED, 5'd0, 8'd0, 1'b0, 9'd0);      // goodness tie keeps current
    send_item(ACT_RESCHED, 5'd0, 8'd0, 1'b0, 9'd511);
    send_item(ACT_RESCHED, 5'd0, 8'd0, 1'b0, 9'd1);      // charge leaves goodness above counter, 17 takes over
    send_item(ACT_WRITE, 5'd0, 8'd0, 1'b0, 9'd0);
    send_item(ACT_RESCHED, 5'd0, 8'd0, 1'b0, 9'd0);      // epoch, current 17 kept
    send_item(ACT_WRITE, 5'd17, 8'd0, 1'b0, 9'd0);
    send_item(ACT_RESCHED, 5'd31, 8'd255, 1'b1, 9'd0);   // nothing runnable, idle slot
  endtask

  // sender holds off until the block has handed back every result
  task automatic test_drain_pause();
    for (int i = 0; i < 4; i++)
      send_item(ACT_WRITE, PID_W'($urandom_range(31)), rand_prio(), 1'b1,
                CNT_W'($urandom_range(511)));
    send_item(ACT_RESCHED, '0, '0, 1'b0, 9'd0);
    wait_results_drained();
    send_item(ACT_RESCHED, '1, '1, 1'b1, rand_ticks());
    send_item(ACT_WRITE, '1, '1, 1'b1, '1);
  endtask

  // mostly bursts of writes, most of them ready, followed by reschedules, some noise items
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned n_items);
    int unsigned sent;
    int unsigned n_wr;
    int unsigned n_rs;
    sent          = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < n_items) begin
      if ($urandom_range(9) < 7) begin
        n_wr = $urandom_range(4, 1);
        n_rs = $urandom_range(8, 2);
        for (int i = 0; i < n_wr; i++)
          send_item(ACT_WRITE, PID_W'($urandom_range(31)), rand_prio(),
                    ($urandom_range(7) != 0), CNT_W'($urandom_range(511)));
        for (int i = 0; i < n_rs; i++)
          send_item(ACT_RESCHED, PID_W'($urandom_range(31)), PRIO_W'($urandom_range(255)),
                    1'($urandom_range(1)), rand_ticks());
        sent += n_wr + n_rs;
      end else begin
        send_item(1'($urandom_range(1)), PID_W'($urandom_range(31)),
                  PRIO_W'($urandom_range(255)), 1'($urandom_range(1)),
                  CNT_W'($urandom_range(511)));
        sent++;
      end
    end
  endtask

  initial begin
    clear_sched_table();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_cases();
    test_drain_pause();
    test_random_traffic(25, 72, 590);
    test_random_traffic(72, 25, 590);
    test_random_traffic(0, 0, 590);
    wait_results_drained();
    // anything that shows up now has no expectation and is flagged
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
